/* hdl/ufrb_pkg.sv */
// ----------------------------------------------------------------------------
// ufrb_pkg
// shared types and constants of the uart fifo register block
// ----------------------------------------------------------------------------
`default_nettype none

package ufrb_pkg;

    // fifo depth default
    localparam int FIFO_DEPTH_DEF = 32;

    // transaction kinds
    typedef enum logic [1:0] {
        OP_BUS_READ  = 2'd0,
        OP_BUS_WRITE = 2'd1,
        OP_LINE_RX   = 2'd2,
        OP_LINE_TX   = 2'd3
    } t_op;

    // bus word indexes
    localparam logic [2:0] ADDR_DATA     = 3'd0;
    localparam logic [2:0] ADDR_CONTROL  = 3'd2;
    localparam logic [2:0] ADDR_TX_LEVEL = 3'd3;
    localparam logic [2:0] ADDR_RX_LEVEL = 3'd4;

    // control register bit positions
    localparam int CT_LOOPBACK  = 16;
    localparam int CT_RESET     = 15;
    localparam int CT_STOP_ERR  = 14;
    localparam int CT_START_ERR = 13;
    localparam int CT_RX_OVF    = 12;
    localparam int CT_TX_OVF    = 11;
    localparam int CT_PAR_ERR   = 10;
    localparam int CT_STICKY_LO = 10;
    localparam int CT_STICKY_HI = 14;

    // sticky bit indexes inside the five bit sticky field
    localparam int STK_PAR   = CT_PAR_ERR   - CT_STICKY_LO;
    localparam int STK_TXOVF = CT_TX_OVF    - CT_STICKY_LO;
    localparam int STK_RXOVF = CT_RX_OVF    - CT_STICKY_LO;
    localparam int STK_START = CT_START_ERR - CT_STICKY_LO;
    localparam int STK_STOP  = CT_STOP_ERR  - CT_STICKY_LO;

    // mode byte after reset: baud select three
    localparam logic [7:0] MODE_RESET = 8'h03;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage : ufrb_pkg

`default_nettype wire

/* hdl/ufrb_ctrl.sv */
// ----------------------------------------------------------------------------
// ufrb_ctrl
// sequencer: takes one transaction, runs it, hands the result out
// ----------------------------------------------------------------------------
`default_nettype none

module ufrb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output ufrb_pkg::t_dp_cmd     o_cmd
);
    import ufrb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait for the output register to be free
                if (out_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule : ufrb_ctrl

`default_nettype wire

/* hdl/ufrb_datapath.sv */
// ----------------------------------------------------------------------------
// ufrb_datapath
// fifo memories, pointers, fill levels, control register and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ufrb_datapath #(
    parameter int FIFO_DEPTH = ufrb_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ufrb_pkg::t_dp_cmd i_cmd,
    input  wire logic [1:0]       i_operation,
    input  wire logic [2:0]       i_address,
    input  wire logic [31:0]      i_write_data,
    input  wire logic [7:0]       i_line_char,
    input  wire logic             i_line_parity_error,
    input  wire logic             i_line_stop_error,
    input  wire logic             i_line_start_error,
    output logic [31:0]           o_read_data,
    output logic                  o_tx_valid,
    output logic [7:0]            o_tx_char,
    output logic                  o_rx_pending
);
    import ufrb_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);
    localparam logic [LVL_W:0]   SUM_DEPTH = (LVL_W+1)'(FIFO_DEPTH);

    // memories
    logic [9:0] rx_mem [FIFO_DEPTH];
    logic [7:0] tx_mem [FIFO_DEPTH];

    // captured transaction
    t_op         r_op;
    logic [2:0]  r_addr;
    logic [31:0] r_wdata;
    logic [7:0]  r_char;
    logic        r_par, r_stp, r_sta;
    logic [9:0]  r_rx_rdata;
    logic [7:0]  r_tx_rdata;

    // fifo state and control register
    logic [PTR_W-1:0] r_rx_rptr, n_rx_rptr, r_tx_rptr, n_tx_rptr;
    logic [LVL_W-1:0] r_rx_level, n_rx_level, r_tx_level, n_tx_level;
    logic             r_loopback, n_loopback;
    logic [4:0]       r_sticky, n_sticky;
    logic [7:0]       r_mode, n_mode;

    // result register
    logic [31:0] r_read_data, n_read_data;
    logic        r_tx_valid, n_tx_valid;
    logic [7:0]  r_tx_char, n_tx_char;
    logic        r_rx_pending, n_rx_pending;

    logic             rx_we, tx_we;
    logic [PTR_W-1:0] rx_wptr, tx_wptr;
    logic             rx_full, tx_full;

    function automatic logic [PTR_W-1:0] wr_ptr(
        input logic [PTR_W-1:0] rptr,
        input logic [LVL_W-1:0] level
    );
        logic [LVL_W:0] sum;
        sum = (LVL_W+1)'(rptr) + (LVL_W+1)'(level);
        if (sum >= SUM_DEPTH) begin
            sum = sum - SUM_DEPTH;
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign rx_wptr = wr_ptr(r_rx_rptr, r_rx_level);
    assign tx_wptr = wr_ptr(r_tx_rptr, r_tx_level);
    assign rx_full = (r_rx_level == LVL_FULL);
    assign tx_full = (r_tx_level == LVL_FULL);

    always_comb begin
        n_rx_rptr   = r_rx_rptr;
        n_tx_rptr   = r_tx_rptr;
        n_rx_level  = r_rx_level;
        n_tx_level  = r_tx_level;
        n_loopback  = r_loopback;
        n_sticky    = r_sticky;
        n_mode      = r_mode;
        n_read_data = '0;
        n_tx_valid  = 1'b0;
        n_tx_char   = '0;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        case (r_op)
            OP_BUS_READ: begin
                case (r_addr)
                    ADDR_DATA: begin
                        if (r_rx_level != '0) begin
                            n_read_data = {20'd0, r_rx_rdata[9], 2'b00,
                                           r_rx_rdata[8], r_rx_rdata[7:0]};
                            n_rx_rptr   = ptr_inc(r_rx_rptr);
                            n_rx_level  = r_rx_level - 1'b1;
                        end
                    end
                    ADDR_CONTROL: begin
                        n_read_data = {15'd0, r_loopback, 1'b0, r_sticky,
                                       (r_tx_level == '0), (r_rx_level == '0), r_mode};
                    end
                    ADDR_TX_LEVEL: n_read_data = 32'(r_tx_level);
                    ADDR_RX_LEVEL: n_read_data = 32'(r_rx_level);
                    default:       n_read_data = '0;
                endcase
            end
            OP_BUS_WRITE: begin
                if (r_addr == ADDR_DATA) begin
                    if (tx_full) begin
                        n_sticky[STK_TXOVF] = 1'b1;
                    end else begin
                        tx_we      = 1'b1;
                        n_tx_level = r_tx_level + 1'b1;
                    end
                end else if (r_addr == ADDR_CONTROL) begin
                    n_loopback = r_wdata[CT_LOOPBACK];
                    n_mode     = r_wdata[7:0];
                    n_sticky   = r_sticky & r_wdata[CT_STICKY_HI:CT_STICKY_LO];
                    if (r_wdata[CT_RESET]) begin
                        n_rx_rptr  = '0;
                        n_tx_rptr  = '0;
                        n_rx_level = '0;
                        n_tx_level = '0;
                    end
                end
            end
            OP_LINE_RX: begin
                n_sticky[STK_PAR]   = r_sticky[STK_PAR]   | r_par;
                n_sticky[STK_STOP]  = r_sticky[STK_STOP]  | r_stp;
                n_sticky[STK_START] = r_sticky[STK_START] | r_sta;
                if (rx_full) begin
                    n_sticky[STK_RXOVF] = 1'b1;
                end else begin
                    rx_we      = 1'b1;
                    n_rx_level = r_rx_level + 1'b1;
                end
            end
            OP_LINE_TX: begin
                if (r_tx_level != '0) begin
                    n_tx_valid = 1'b1;
                    n_tx_char  = r_tx_rdata;
                    n_tx_rptr  = ptr_inc(r_tx_rptr);
                    n_tx_level = r_tx_level - 1'b1;
                end
            end
            default: begin
                n_read_data = '0;
            end
        endcase
        n_rx_pending = (n_rx_level != '0);
    end

    // capture of the transaction and the heads of both fifos
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= t_op'(i_operation);
            r_addr     <= i_address;
            r_wdata    <= i_write_data;
            r_char     <= i_line_char;
            r_par      <= i_line_parity_error;
            r_stp      <= i_line_stop_error;
            r_sta      <= i_line_start_error;
            r_rx_rdata <= rx_mem[r_rx_rptr];
            r_tx_rdata <= tx_mem[r_tx_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && rx_we) begin
            rx_mem[rx_wptr] <= {r_stp, r_par, r_char};
        end
        if (i_cmd.execute && tx_we) begin
            tx_mem[tx_wptr] <= r_wdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_rptr  <= '0;
            r_tx_rptr  <= '0;
            r_rx_level <= '0;
            r_tx_level <= '0;
            r_loopback <= 1'b0;
            r_sticky   <= '0;
            r_mode     <= MODE_RESET;
        end else if (i_cmd.execute) begin
            r_rx_rptr  <= n_rx_rptr;
            r_tx_rptr  <= n_tx_rptr;
            r_rx_level <= n_rx_level;
            r_tx_level <= n_tx_level;
            r_loopback <= n_loopback;
            r_sticky   <= n_sticky;
            r_mode     <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_read_data  <= n_read_data;
            r_tx_valid   <= n_tx_valid;
            r_tx_char    <= n_tx_char;
            r_rx_pending <= n_rx_pending;
        end
    end

    assign o_read_data  = r_read_data;
    assign o_tx_valid   = r_tx_valid;
    assign o_tx_char    = r_tx_char;
    assign o_rx_pending = r_rx_pending;

endmodule : ufrb_datapath

`default_nettype wire

/* hdl/uart_fifo_register_block_unit.sv */
// ----------------------------------------------------------------------------
// uart_fifo_register_block_unit
// register-mapped uart core with receive and transmit fifos
// ----------------------------------------------------------------------------
// Each input transaction is one of: a bus read, a bus write, a character
// arriving from the line, or a transmit slot on the line; each gives exactly
// one result transaction. Bus word 0 is the data port, word 2 the control
// register, word 3 the transmit fill level and word 4 the receive fill level.
// A transaction is first captured together with the head entries of both
// fifo memories (read data is registered), then the register update runs and
// loads the result register. The input side therefore cannot take a new
// transaction before the last one has run, held back by the registered
// memory read in front of the update. The result register parts the two
// sides, so the next transaction may be taken while a result still waits.
// No clearing pass is needed after reset: fill levels guard every fifo read.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_fifo_register_block_unit #(
    parameter int FIFO_DEPTH = ufrb_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transaction channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [2:0]  i_address,
    input  wire logic [31:0] i_write_data,
    input  wire logic [7:0]  i_line_char,
    input  wire logic        i_line_parity_error,
    input  wire logic        i_line_stop_error,
    input  wire logic        i_line_start_error,
    // result transaction channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_read_data,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_char,
    output logic             o_rx_pending
);
    import ufrb_pkg::*;

    // commands from the sequencer to the datapath
    t_dp_cmd cmd;

    // sequencer: idle / execute, owns both handshakes
    ufrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // datapath: fifos, levels, control register, result register
    ufrb_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_operation         (i_operation),
        .i_address           (i_address),
        .i_write_data        (i_write_data),
        .i_line_char         (i_line_char),
        .i_line_parity_error (i_line_parity_error),
        .i_line_stop_error   (i_line_stop_error),
        .i_line_start_error  (i_line_start_error),
        .o_read_data         (o_read_data),
        .o_tx_valid          (o_tx_valid),
        .o_tx_char           (o_tx_char),
        .o_rx_pending        (o_rx_pending)
    );

endmodule : uart_fifo_register_block_unit

`default_nettype wire
